/* hdl/mfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_pkg
// Shared types, codes and size limits of the multichannel filter response
// engine.
// ----------------------------------------------------------------------------
package mfr_pkg;

  // Default size limits; the top level hands its own values down.
  localparam int MAX_MAP_H_DEF    = 64;
  localparam int MAX_MAP_W_DEF    = 64;
  localparam int MAX_CHANNELS_DEF = 32;
  localparam int MAX_FILT_H_DEF   = 16;
  localparam int MAX_FILT_W_DEF   = 16;

  // Reset values of the size registers before limiting to the maxima.
  localparam int MAP_H_RST  = 64;
  localparam int MAP_W_RST  = 64;
  localparam int CHAN_RST   = 32;
  localparam int FILT_H_RST = 8;
  localparam int FILT_W_RST = 8;

  // Field widths.
  localparam int MODE_W   = 2;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 6;
  localparam int CHAN_W   = 5;
  localparam int VALUE_W  = 16;
  localparam int RESP_W   = 48;
  localparam int STATUS_W = 2;
  localparam int PROD_W   = 2 * VALUE_W;

  // Configuration port.
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_MAP_H  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAP_W  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CHAN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FILT_H = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FILT_W = 3'd4;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_MAP_WR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FILT_WR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SIZE  = 2'd2;

  // Active sizes, as held in the configuration registers.
  typedef struct packed {
    logic [6:0] map_h;
    logic [6:0] map_w;
    logic [5:0] chan;
    logic [4:0] filt_h;
    logic [4:0] filt_w;
  } mfr_cfg_t;

  function automatic int clamp_size(int v, int hi);
    if (v < 1) begin
      return 1;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

endpackage

/* hdl/mfr_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_in_if
// Input channel: one map write, filter write or response request per
// transaction.
// ----------------------------------------------------------------------------
interface mfr_in_if import mfr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic [ROW_W-1:0]           row;
  logic [COL_W-1:0]           col;
  logic [CHAN_W-1:0]          channel;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, mode, row, col, channel, value, input ready);
  modport sink (input valid, mode, row, col, channel, value, output ready);
endinterface

/* hdl/mfr_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_out_if
// Result channel: one response and status per transaction.
// ----------------------------------------------------------------------------
interface mfr_out_if import mfr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [RESP_W-1:0]  response;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, response, status, input ready);
  modport sink (input valid, response, status, output ready);
endinterface

/* hdl/mfr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mfr_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/mfr_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_cfg
// APB-style register file for the active map and filter sizes.
// ----------------------------------------------------------------------------
module mfr_cfg import mfr_pkg::*; #(
  parameter int MAX_MAP_H    = MAX_MAP_H_DEF,
  parameter int MAX_MAP_W    = MAX_MAP_W_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_FILT_H   = MAX_FILT_H_DEF,
  parameter int MAX_FILT_W   = MAX_FILT_W_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output mfr_cfg_t          cfg
);

  localparam logic [6:0] MAP_H_INIT  = 7'(clamp_size(MAP_H_RST, MAX_MAP_H));
  localparam logic [6:0] MAP_W_INIT  = 7'(clamp_size(MAP_W_RST, MAX_MAP_W));
  localparam logic [5:0] CHAN_INIT   = 6'(clamp_size(CHAN_RST, MAX_CHANNELS));
  localparam logic [4:0] FILT_H_INIT = 5'(clamp_size(FILT_H_RST, MAX_FILT_H));
  localparam logic [4:0] FILT_W_INIT = 5'(clamp_size(FILT_W_RST, MAX_FILT_W));

  mfr_cfg_t               cfg_r;
  logic                   wr_en;
  logic [REG_IDX_W-1:0]   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.map_h  <= MAP_H_INIT;
      cfg_r.map_w  <= MAP_W_INIT;
      cfg_r.chan   <= CHAN_INIT;
      cfg_r.filt_h <= FILT_H_INIT;
      cfg_r.filt_w <= FILT_W_INIT;
    end else if (wr_en) begin
      // Written values are held within one and the configured maximum.
      unique case (reg_idx)
        REG_MAP_H:  cfg_r.map_h  <= 7'(clamp_size(int'(pwdata[6:0]), MAX_MAP_H));
        REG_MAP_W:  cfg_r.map_w  <= 7'(clamp_size(int'(pwdata[6:0]), MAX_MAP_W));
        REG_CHAN:   cfg_r.chan   <= 6'(clamp_size(int'(pwdata[5:0]), MAX_CHANNELS));
        REG_FILT_H: cfg_r.filt_h <= 5'(clamp_size(int'(pwdata[4:0]), MAX_FILT_H));
        REG_FILT_W: cfg_r.filt_w <= 5'(clamp_size(int'(pwdata[4:0]), MAX_FILT_W));
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAP_H:  prdata = {25'd0, cfg_r.map_h};
      REG_MAP_W:  prdata = {25'd0, cfg_r.map_w};
      REG_CHAN:   prdata = {26'd0, cfg_r.chan};
      REG_FILT_H: prdata = {27'd0, cfg_r.filt_h};
      REG_FILT_W: prdata = {27'd0, cfg_r.filt_w};
      default:    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* hdl/mfr_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_engine
// Item sequencer: checks each transaction, writes the stores, and walks
// the filter window with one multiply-accumulate per cycle.
// ----------------------------------------------------------------------------
module mfr_engine import mfr_pkg::*; #(
  parameter int MAX_MAP_H    = MAX_MAP_H_DEF,
  parameter int MAX_MAP_W    = MAX_MAP_W_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_FILT_H   = MAX_FILT_H_DEF,
  parameter int MAX_FILT_W   = MAX_FILT_W_DEF,
  parameter int MAW          = 17,
  parameter int FAW          = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mfr_cfg_t             cfg,
  mfr_in_if.sink               in_ch,
  mfr_out_if.source            out_ch,
  output logic                 map_we,
  output logic [MAW-1:0]       map_waddr,
  output logic                 map_re,
  output logic [MAW-1:0]       map_raddr,
  input  logic [VALUE_W-1:0]   map_rdata,
  output logic                 filt_we,
  output logic [FAW-1:0]       filt_waddr,
  output logic                 filt_re,
  output logic [FAW-1:0]       filt_raddr,
  input  logic [VALUE_W-1:0]   filt_rdata,
  output logic [VALUE_W-1:0]   wdata
);

  localparam int MAP_ROW  = MAX_MAP_W * MAX_CHANNELS;
  localparam int FILT_ROW = MAX_FILT_W * MAX_CHANNELS;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_RUN   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                     state_r, state_nxt;

  // Accepted transaction.
  logic [MODE_W-1:0]          mode_r;
  logic [ROW_W-1:0]           row_r;
  logic [COL_W-1:0]           col_r;
  logic [CHAN_W-1:0]          ch_r;
  logic [VALUE_W-1:0]         val_r;

  // Window walk.
  logic [4:0]                 i_r, i_nxt;
  logic [4:0]                 j_r, j_nxt;
  logic [5:0]                 c_r, c_nxt;
  logic [MAW-1:0]             map_row_r, map_row_nxt, map_pos_r, map_pos_nxt;
  logic [FAW-1:0]             filt_row_r, filt_row_nxt, filt_pos_r, filt_pos_nxt;

  logic [STATUS_W-1:0]        status_r, status_nxt, chk_status;
  logic                       rd_vld_r, prod_vld_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [RESP_W-1:0]   acc_r, acc_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [RESP_W-1:0]   out_resp_r;
  logic [STATUS_W-1:0]        out_status_r;

  logic                       in_fire, out_free, last_c, last_j, last_i;
  logic [MAW-1:0]             map_base;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Status of the held transaction against the active sizes.
  always_comb begin
    unique case (mode_r)
      MODE_MAP_WR: begin
        chk_status = ({1'b0, row_r} < cfg.map_h && {1'b0, col_r} < cfg.map_w &&
                      {1'b0, ch_r} < cfg.chan) ? ST_OK : ST_RANGE;
      end
      MODE_FILT_WR: begin
        chk_status = ({1'b0, row_r} < {2'b0, cfg.filt_h} &&
                      {1'b0, col_r} < {2'b0, cfg.filt_w} &&
                      {1'b0, ch_r} < cfg.chan) ? ST_OK : ST_RANGE;
      end
      MODE_COMPUTE: begin
        if ({2'b0, cfg.filt_h} > cfg.map_h || {2'b0, cfg.filt_w} > cfg.map_w) begin
          chk_status = ST_SIZE;
        end else if ({1'b0, row_r} > cfg.map_h - {2'b0, cfg.filt_h} ||
                     {1'b0, col_r} > cfg.map_w - {2'b0, cfg.filt_w}) begin
          chk_status = ST_RANGE;
        end else begin
          chk_status = ST_OK;
        end
      end
      default: chk_status = ST_RANGE;
    endcase
  end

  // Store addresses: row-major, channel fastest.
  assign map_waddr = MAW'(int'(row_r) * MAP_ROW + int'(col_r) * MAX_CHANNELS + int'(ch_r));
  assign filt_waddr = FAW'(int'(row_r) * FILT_ROW + int'(col_r) * MAX_CHANNELS + int'(ch_r));
  assign map_base  = MAW'(int'(row_r) * MAP_ROW + int'(col_r) * MAX_CHANNELS);
  assign wdata     = val_r;

  assign map_we  = (state_r == S_CHECK) && (mode_r == MODE_MAP_WR) && (chk_status == ST_OK);
  assign filt_we = (state_r == S_CHECK) && (mode_r == MODE_FILT_WR) && (chk_status == ST_OK);

  assign map_re     = (state_r == S_RUN);
  assign filt_re    = (state_r == S_RUN);
  assign map_raddr  = map_pos_r + MAW'(c_r);
  assign filt_raddr = filt_pos_r + FAW'(c_r);

  assign last_c = (c_r == cfg.chan - 6'd1);
  assign last_j = (j_r == cfg.filt_w - 5'd1);
  assign last_i = (i_r == cfg.filt_h - 5'd1);

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    c_nxt         = c_r;
    map_row_nxt   = map_row_r;
    map_pos_nxt   = map_pos_r;
    filt_row_nxt  = filt_row_r;
    filt_pos_nxt  = filt_pos_r;
    status_nxt    = status_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // The accumulator takes each product in the cycle after the multiplier.
    if (prod_vld_r) begin
      acc_nxt = acc_r + RESP_W'(prod_r);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        status_nxt   = chk_status;
        acc_nxt      = '0;
        i_nxt        = '0;
        j_nxt        = '0;
        c_nxt        = '0;
        map_row_nxt  = map_base;
        map_pos_nxt  = map_base;
        filt_row_nxt = '0;
        filt_pos_nxt = '0;
        state_nxt    = (mode_r == MODE_COMPUTE && chk_status == ST_OK) ? S_RUN : S_DONE;
      end
      S_RUN: begin
        if (!last_c) begin
          c_nxt = c_r + 6'd1;
        end else begin
          c_nxt = '0;
          if (!last_j) begin
            j_nxt        = j_r + 5'd1;
            map_pos_nxt  = map_pos_r + MAW'(MAX_CHANNELS);
            filt_pos_nxt = filt_pos_r + FAW'(MAX_CHANNELS);
          end else begin
            j_nxt = '0;
            if (!last_i) begin
              i_nxt        = i_r + 5'd1;
              map_row_nxt  = map_row_r + MAW'(MAP_ROW);
              map_pos_nxt  = map_row_r + MAW'(MAP_ROW);
              filt_row_nxt = filt_row_r + FAW'(FILT_ROW);
              filt_pos_nxt = filt_row_r + FAW'(FILT_ROW);
            end else begin
              state_nxt = S_DRAIN;
            end
          end
        end
      end
      S_DRAIN: begin
        if (!rd_vld_r && !prod_vld_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= (state_r == S_RUN);
      prod_vld_r  <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_ch.mode;
      row_r  <= in_ch.row;
      col_r  <= in_ch.col;
      ch_r   <= in_ch.channel;
      val_r  <= in_ch.value;
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    c_r        <= c_nxt;
    map_row_r  <= map_row_nxt;
    map_pos_r  <= map_pos_nxt;
    filt_row_r <= filt_row_nxt;
    filt_pos_r <= filt_pos_nxt;
    status_r   <= status_nxt;
    acc_r      <= acc_nxt;
    if (rd_vld_r) begin
      prod_r <= $signed(map_rdata) * $signed(filt_rdata);
    end
    if (state_r == S_DONE && out_free) begin
      out_resp_r   <= (status_r == ST_OK) ? acc_r : '0;
      out_status_r <= status_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.response = out_resp_r;
  assign out_ch.status   = out_status_r;

endmodule

/* hdl/multichannel_filter_response_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_filter_response_top
// Multichannel 2-D valid cross-correlation engine with map and filter
// stores in on-chip RAM.
//
//   Channel   Direction  Carries
//   in_ch     sink       mode, row, col, channel, value (one item)
//   out_ch    source     response, status (one per item)
//   cfg (APB) slave      map/filter sizes, byte address 4 * register index
//
// A map or filter write, or any rejected item, passes from acceptance
// through the check and done states to the output register. A response
// first takes filter_height * filter_width * channel_count terms, one
// multiply-accumulate per cycle over the single read port of each store.
// Reset clears only control state; the stores hold nothing until written.
// A result waits in the output register while the next item is accepted;
// a held-off result stalls the item behind it before it is delivered.
// ----------------------------------------------------------------------------
module multichannel_filter_response_top import mfr_pkg::*; #(
  parameter int MAX_MAP_H    = MAX_MAP_H_DEF,
  parameter int MAX_MAP_W    = MAX_MAP_W_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_FILT_H   = MAX_FILT_H_DEF,
  parameter int MAX_FILT_W   = MAX_FILT_W_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  mfr_in_if.sink            in_ch,
  mfr_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int MAP_DEPTH  = MAX_MAP_H * MAX_MAP_W * MAX_CHANNELS;
  localparam int FILT_DEPTH = MAX_FILT_H * MAX_FILT_W * MAX_CHANNELS;
  localparam int MAW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int FAW = (FILT_DEPTH > 1) ? $clog2(FILT_DEPTH) : 1;

  mfr_cfg_t            cfg;
  logic                map_we, map_re, filt_we, filt_re;
  logic [MAW-1:0]      map_waddr, map_raddr;
  logic [FAW-1:0]      filt_waddr, filt_raddr;
  logic [VALUE_W-1:0]  map_rdata, filt_rdata, wdata;

  mfr_cfg #(
    .MAX_MAP_H    (MAX_MAP_H),
    .MAX_MAP_W    (MAX_MAP_W),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_FILT_H   (MAX_FILT_H),
    .MAX_FILT_W   (MAX_FILT_W)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mfr_ram #(
    .DEPTH (MAP_DEPTH),
    .AW    (MAW),
    .DW    (VALUE_W)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  mfr_ram #(
    .DEPTH (FILT_DEPTH),
    .AW    (FAW),
    .DW    (VALUE_W)
  ) u_filt_ram (
    .clk   (clk),
    .we    (filt_we),
    .waddr (filt_waddr),
    .wdata (wdata),
    .re    (filt_re),
    .raddr (filt_raddr),
    .rdata (filt_rdata)
  );

  mfr_engine #(
    .MAX_MAP_H    (MAX_MAP_H),
    .MAX_MAP_W    (MAX_MAP_W),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_FILT_H   (MAX_FILT_H),
    .MAX_FILT_W   (MAX_FILT_W),
    .MAW          (MAW),
    .FAW          (FAW)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .map_we     (map_we),
    .map_waddr  (map_waddr),
    .map_re     (map_re),
    .map_raddr  (map_raddr),
    .map_rdata  (map_rdata),
    .filt_we    (filt_we),
    .filt_waddr (filt_waddr),
    .filt_re    (filt_re),
    .filt_raddr (filt_raddr),
    .filt_rdata (filt_rdata),
    .wdata      (wdata)
  );

endmodule

/* tb/sv/tb_multichannel_filter_response_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_filter_response_top
// Self-checking bench for the multichannel filter response engine. A
// behavioural copy of the map store, the filter store and the size
// registers predicts the response and status of every transaction. Directed
// tests cover register limits, index checks, oversize filters, the smallest
// shapes, the full map size and full-scale products. Random phases then
// follow, each with its own sizes. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_multichannel_filter_response_top;
  import mfr_pkg::*;

  localparam int MAP_DEPTH  = MAX_MAP_H_DEF * MAX_MAP_W_DEF * MAX_CHANNELS_DEF;
  localparam int FILT_DEPTH = MAX_FILT_H_DEF * MAX_FILT_W_DEF * MAX_CHANNELS_DEF;

  // Codes that the package leaves unnamed.
  localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPARE  = 3'd5;

  typedef struct {
    logic [MODE_W-1:0]         mode;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic [CHAN_W-1:0]         channel;
    logic signed [VALUE_W-1:0] value;
  } request_t;

  typedef struct {
    logic signed [RESP_W-1:0] response;
    logic [STATUS_W-1:0]      status;
  } outcome_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  mfr_in_if  in_ch ();
  mfr_out_if out_ch ();

  multichannel_filter_response_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the engine's state.
  logic signed [VALUE_W-1:0] map_copy [MAP_DEPTH];
  logic signed [VALUE_W-1:0] filt_copy [FILT_DEPTH];
  mfr_cfg_t                  sizes;

  outcome_t awaited_results [$];
  int       fail_count;
  bit       idle_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  function automatic int bound(input int v, input int hi);
    if (v < 1) begin
      return 1;
    end
    return (v > hi) ? hi : v;
  endfunction

  function automatic int map_addr(input int r, input int c, input int ch);
    return (r * MAX_MAP_W_DEF + c) * MAX_CHANNELS_DEF + ch;
  endfunction

  function automatic int filt_addr(input int r, input int c, input int ch);
    return (r * MAX_FILT_W_DEF + c) * MAX_CHANNELS_DEF + ch;
  endfunction

  function automatic int draw_wait();
    return idle_on ? $urandom_range(0, 13) : 0;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Applies one accepted transaction to the mirror and returns its result.
  function automatic outcome_t correlate_item(input request_t req);
    outcome_t                 res;
    int                       r, c, ch, mh, mw, nch, fh, fw;
    logic signed [PROD_W-1:0] prod;
    r   = req.row;
    c   = req.col;
    ch  = req.channel;
    mh  = sizes.map_h;
    mw  = sizes.map_w;
    nch = sizes.chan;
    fh  = sizes.filt_h;
    fw  = sizes.filt_w;
    res.response = '0;
    res.status   = ST_OK;
    case (req.mode)
      MODE_MAP_WR: begin
        if (r < mh && c < mw && ch < nch) begin
          map_copy[map_addr(r, c, ch)] = req.value;
        end else begin
          res.status = ST_RANGE;
        end
      end
      MODE_FILT_WR: begin
        if (r < fh && c < fw && ch < nch) begin
          filt_copy[filt_addr(r, c, ch)] = req.value;
        end else begin
          res.status = ST_RANGE;
        end
      end
      MODE_COMPUTE: begin
        if (fh > mh || fw > mw) begin
          res.status = ST_SIZE;
        end else if (r > mh - fh || c > mw - fw) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = 0; i < fh; i++) begin
            for (int j = 0; j < fw; j++) begin
              for (int k = 0; k < nch; k++) begin
                prod = map_copy[map_addr(r + i, c + j, k)] * filt_copy[filt_addr(i, j, k)];
                res.response = res.response + prod;
              end
            end
          end
        end
      end
      default: res.status = ST_RANGE;
    endcase
    return res;
  endfunction

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MAP_H:  sizes.map_h  = 7'(bound(data[6:0], MAX_MAP_H_DEF));
      REG_MAP_W:  sizes.map_w  = 7'(bound(data[6:0], MAX_MAP_W_DEF));
      REG_CHAN:   sizes.chan   = 6'(bound(data[5:0], MAX_CHANNELS_DEF));
      REG_FILT_H: sizes.filt_h = 5'(bound(data[4:0], MAX_FILT_H_DEF));
      REG_FILT_W: sizes.filt_w = 5'(bound(data[4:0], MAX_FILT_W_DEF));
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [REG_IDX_W-1:0] idx, input int want);
    logic [CFG_DW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== CFG_DW'(want)) begin
      fail_count++;
      $display("%0t ns: register %0d read mismatch, expected %0d, got %0d",
               $time, idx, want, got);
    end
    @(posedge clk);
  endtask

  task automatic verify_sizes();
    check_reg(REG_MAP_H, sizes.map_h);
    check_reg(REG_MAP_W, sizes.map_w);
    check_reg(REG_CHAN, sizes.chan);
    check_reg(REG_FILT_H, sizes.filt_h);
    check_reg(REG_FILT_W, sizes.filt_w);
  endtask

  task automatic issue_item(input logic [MODE_W-1:0] mode, input int row, input int col,
                            input int channel, input logic signed [VALUE_W-1:0] value);
    request_t req;
    int       gap;
    req.mode    = mode;
    req.row     = ROW_W'(row);
    req.col     = COL_W'(col);
    req.channel = CHAN_W'(channel);
    req.value   = value;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= req.mode;
    in_ch.row     <= req.row;
    in_ch.col     <= req.col;
    in_ch.channel <= req.channel;
    in_ch.value   <= req.value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    awaited_results.push_back(correlate_item(req));
  endtask

  // Drops valid and waits until every result has been delivered.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_sizes(input int mh, input int mw, input int nch, input int fh,
                           input int fw);
    drain();
    cfg_write(REG_MAP_H, mh);
    cfg_write(REG_MAP_W, mw);
    cfg_write(REG_CHAN, nch);
    cfg_write(REG_FILT_H, fh);
    cfg_write(REG_FILT_W, fw);
  endtask

  task automatic fill_map(input int r0, input int r1, input int c0, input int c1,
                          input bit fixed, input logic signed [VALUE_W-1:0] v);
    for (int r = r0; r <= r1; r++) begin
      for (int c = c0; c <= c1; c++) begin
        for (int k = 0; k < sizes.chan; k++) begin
          issue_item(MODE_MAP_WR, r, c, k, fixed ? v : pick_value());
        end
      end
    end
  endtask

  task automatic fill_filter(input bit fixed, input logic signed [VALUE_W-1:0] v);
    for (int r = 0; r < sizes.filt_h; r++) begin
      for (int c = 0; c < sizes.filt_w; c++) begin
        for (int k = 0; k < sizes.chan; k++) begin
          issue_item(MODE_FILT_WR, r, c, k, fixed ? v : pick_value());
        end
      end
    end
  endtask

  // Reset sizes: only writes and rejected requests, since nothing is stored yet.
  task automatic test_reset_sizes();
    verify_sizes();
    issue_item(MODE_MAP_WR, 63, 63, 31, 16'sh7FFF);
    issue_item(MODE_MAP_WR, 0, 0, 0, 16'sh8000);
    issue_item(MODE_FILT_WR, 7, 7, 31, 16'sh8000);
    issue_item(MODE_FILT_WR, 8, 0, 0, 16'sh1234);
    issue_item(MODE_FILT_WR, 0, 8, 0, 16'sh1234);
    issue_item(MODE_SPARE, 1, 1, 1, 16'sh0001);
    issue_item(MODE_COMPUTE, 57, 0, 0, 16'sh0000);
    issue_item(MODE_COMPUTE, 0, 57, 31, 16'shFFFF);
  endtask

  task automatic test_registers();
    drain();
    cfg_write(REG_MAP_H, 0);
    cfg_write(REG_MAP_W, 0);
    cfg_write(REG_CHAN, 0);
    cfg_write(REG_FILT_H, 0);
    cfg_write(REG_FILT_W, 0);
    verify_sizes();
    cfg_write(REG_MAP_H, 32'hFFFF_FFFF);
    cfg_write(REG_MAP_W, 32'hFFFF_FFFF);
    cfg_write(REG_CHAN, 32'hFFFF_FFFF);
    cfg_write(REG_FILT_H, 32'hFFFF_FFFF);
    cfg_write(REG_FILT_W, 32'hFFFF_FFFF);
    verify_sizes();
    // Bits above the register width are dropped before the range limit.
    cfg_write(REG_MAP_H, 32'h0000_0080);
    cfg_write(REG_CHAN, 32'h0000_0045);
    cfg_write(REG_FILT_W, 32'h0000_0023);
    cfg_write(REG_SPARE, 32'h0000_0003);
    verify_sizes();
  endtask

  task automatic test_small_window();
    set_sizes(3, 3, 1, 2, 2);
    verify_sizes();
    fill_map(0, 2, 0, 2, 1'b0, '0);
    fill_filter(1'b0, '0);
    issue_item(MODE_COMPUTE, 0, 0, 0, '0);
    issue_item(MODE_COMPUTE, 2, 2, 0, '0);
    issue_item(MODE_COMPUTE, 1, 1, 31, 16'sh7FFF);
    issue_item(MODE_COMPUTE, 3, 0, 0, '0);
    issue_item(MODE_COMPUTE, 0, 3, 0, '0);
    issue_item(MODE_MAP_WR, 0, 0, 2, 16'sh0101);
    issue_item(MODE_MAP_WR, 4, 0, 0, 16'sh0101);
    issue_item(MODE_FILT_WR, 0, 3, 0, 16'sh0101);
    issue_item(MODE_FILT_WR, 2, 0, 0, 16'sh0101);
    issue_item(MODE_MAP_WR, 2, 2, 0, 16'sh8000);
    issue_item(MODE_COMPUTE, 1, 1, 0, '0);
  endtask

  task automatic test_filter_too_big();
    set_sizes(4, 4, 2, 5, 2);
    issue_item(MODE_FILT_WR, 4, 1, 1, 16'sh0FFF);
    issue_item(MODE_COMPUTE, 0, 0, 0, '0);
    issue_item(MODE_COMPUTE, 63, 63, 0, '0);
    set_sizes(4, 4, 2, 2, 5);
    issue_item(MODE_COMPUTE, 0, 0, 0, '0);
  endtask

  task automatic test_minimum_sizes();
    set_sizes(1, 1, 1, 1, 1);
    fill_map(0, 0, 0, 0, 1'b0, '0);
    fill_filter(1'b0, '0);
    issue_item(MODE_COMPUTE, 0, 0, 0, '0);
    issue_item(MODE_COMPUTE, 0, 1, 0, '0);
    issue_item(MODE_COMPUTE, 1, 0, 0, '0);
    issue_item(MODE_MAP_WR, 1, 0, 0, 16'sh4000);
    issue_item(MODE_FILT_WR, 0, 0, 1, 16'sh4000);
  endtask

  // Full map size with one channel; only the two corner windows are filled.
  task automatic test_wide_map();
    set_sizes(64, 64, 1, 2, 2);
    fill_map(62, 63, 62, 63, 1'b0, '0);
    fill_map(0, 1, 0, 1, 1'b0, '0);
    fill_filter(1'b0, '0);
    issue_item(MODE_COMPUTE, 62, 62, 0, '0);
    issue_item(MODE_COMPUTE, 0, 0, 0, '0);
    issue_item(MODE_COMPUTE, 63, 0, 0, '0);
    issue_item(MODE_COMPUTE, 0, 63, 0, '0);
    issue_item(MODE_MAP_WR, 63, 63, 1, 16'sh2222);
  endtask

  // Two channels with the largest positive products in every term, then one filter tap changed.
  task automatic test_full_scale();
    set_sizes(1, 2, 2, 1, 2);
    idle_on = 1'b0;
    fill_map(0, 0, 0, 1, 1'b1, 16'sh8000);
    fill_filter(1'b1, 16'sh8000);
    idle_on = 1'b1;
    issue_item(MODE_COMPUTE, 0, 0, 0, '0);
    issue_item(MODE_COMPUTE, 0, 1, 0, '0);
    issue_item(MODE_FILT_WR, 0, 1, 1, 16'sh7FFF);
    issue_item(MODE_COMPUTE, 0, 0, 0, '0);
  endtask

  task automatic test_random();
    int mh, mw, nch, fh, fw;
    for (int phase = 0; phase < 3; phase++) begin
      mh  = $urandom_range(1, 3);
      mw  = $urandom_range(1, 3);
      nch = $urandom_range(1, 2);
      fh  = $urandom_range(1, mh);
      fw  = $urandom_range(1, mw);
      if (phase == 2) begin
        fh = mh + 1;
      end
      set_sizes(mh, mw, nch, fh, fw);
      idle_on = (phase != 1);
      fill_map(0, mh - 1, 0, mw - 1, 1'b0, '0);
      fill_filter(1'b0, '0);
      for (int n = 0; n < 4; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: issue_item(MODE_MAP_WR, $urandom_range(0, mh - 1),
                              $urandom_range(0, mw - 1), $urandom_range(0, nch - 1),
                              pick_value());
          3, 4: issue_item(MODE_FILT_WR, $urandom_range(0, fh - 1),
                           $urandom_range(0, fw - 1), $urandom_range(0, nch - 1),
                           pick_value());
          5, 6, 7: begin
            if (fh > mh || fw > mw) begin
              issue_item(MODE_COMPUTE, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 31), VALUE_W'($urandom));
            end else begin
              issue_item(MODE_COMPUTE, $urandom_range(0, mh - fh), $urandom_range(0, mw - fw),
                         $urandom_range(0, 31), VALUE_W'($urandom));
            end
          end
          8: issue_item(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                        $urandom_range(0, 63), $urandom_range(0, 31), VALUE_W'($urandom));
          default: issue_item(MODE_COMPUTE, $urandom_range(0, 63), $urandom_range(0, 63),
                              $urandom_range(0, 31), VALUE_W'($urandom));
        endcase
      end
    end
    idle_on = 1'b1;
  endtask

  // Takes each result transaction and compares it with the oldest prediction.
  initial begin : result_check
    outcome_t want;
    int       stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (awaited_results.size() == 0) begin
        fail_count++;
        $display("%0t ns: unexpected result, expected none, got response %0d status %0d",
                 $time, out_ch.response, out_ch.status);
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.response !== want.response) begin
          fail_count++;
          $display("%0t ns: response mismatch, expected %0d, got %0d",
                   $time, want.response, out_ch.response);
        end
        if (out_ch.status !== want.status) begin
          fail_count++;
          $display("%0t ns: status mismatch, expected %0d, got %0d",
                   $time, want.status, out_ch.status);
        end
      end
    end
  end

  initial begin
    fail_count    = 0;
    idle_on       = 1'b1;
    sizes.map_h   = 7'(bound(MAP_H_RST, MAX_MAP_H_DEF));
    sizes.map_w   = 7'(bound(MAP_W_RST, MAX_MAP_W_DEF));
    sizes.chan    = 6'(bound(CHAN_RST, MAX_CHANNELS_DEF));
    sizes.filt_h  = 5'(bound(FILT_H_RST, MAX_FILT_H_DEF));
    sizes.filt_w  = 5'(bound(FILT_W_RST, MAX_FILT_W_DEF));
    rst_n         <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= MODE_MAP_WR;
    in_ch.row     <= '0;
    in_ch.col     <= '0;
    in_ch.channel <= '0;
    in_ch.value   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_sizes();
    test_registers();
    test_small_window();
    test_filter_too_big();
    test_minimum_sizes();
    test_wide_map();
    test_full_scale();
    test_random();

    drain();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* multichannel_filter_response_top.f */
hdl/mfr_pkg.sv
hdl/mfr_in_if.sv
hdl/mfr_out_if.sv
hdl/mfr_ram.sv
hdl/mfr_cfg.sv
hdl/mfr_engine.sv
hdl/multichannel_filter_response_top.sv
tb/sv/tb_multichannel_filter_response_top.sv
